### src/fstp_pkg.sv
// Shared types, codes and constant tables of the fair-share task picker.
package fstp_pkg;

   // Default sizes of the slot table.
   localparam int SLOTS_DEFAULT = 64;
   localparam int VRUNTIME_BITS_DEFAULT = 48;

   // Fixed field widths.
   localparam int NICE_W = 6;
   localparam int WEIGHT_W = 17;
   localparam int BUDGET_W = 16;
   localparam int PROD_W = BUDGET_W + WEIGHT_W;
   localparam int CHAN_W = 32;
   localparam int RSP_VR_W = 48;
   localparam int NICE_MAX = 39;

   // Reset values of the configuration registers.
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd10000;
   localparam logic [NICE_W-1:0] DEF_NICE_RESET = 6'd20;

   typedef enum logic [3:0] {
      OP_PICK    = 4'd0,
      OP_WAKE    = 4'd1,
      OP_SLEEP   = 4'd2,
      OP_YIELD   = 4'd3,
      OP_CREATE  = 4'd4,
      OP_FORK    = 4'd5,
      OP_SETNICE = 4'd6,
      OP_GETNICE = 4'd7,
      OP_CHARGE  = 4'd8,
      OP_REMOVE  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      RES_OK       = 2'd0,
      RES_NONE     = 2'd1,
      RES_BAD_NICE = 2'd2,
      RES_UNUSED   = 2'd3
   } result_type;

   typedef enum logic [1:0] {
      SLOT_UNUSED   = 2'd0,
      SLOT_SLEEPING = 2'd1,
      SLOT_RUNNABLE = 2'd2,
      SLOT_RUNNING  = 2'd3
   } slot_state_type;

   typedef enum logic [0:0] {
      CSR_SLICE_BUDGET = 1'b0,
      CSR_DEFAULT_NICE = 1'b1
   } csr_index_type;

   // Write enables of the slot table.
   typedef struct packed {
      logic status;
      logic nice;
      logic vr;
      logic chan;
   } slot_we_type;

   // Scheduling weight of a nice level; levels above the maximum use the last entry.
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [NICE_W-1:0] nice);
      logic [WEIGHT_W-1:0] w;
      case (nice)
         6'd0:  w = 17'd88761;
         6'd1:  w = 17'd71755;
         6'd2:  w = 17'd56483;
         6'd3:  w = 17'd46273;
         6'd4:  w = 17'd36291;
         6'd5:  w = 17'd29154;
         6'd6:  w = 17'd23254;
         6'd7:  w = 17'd18705;
         6'd8:  w = 17'd14949;
         6'd9:  w = 17'd11916;
         6'd10: w = 17'd9548;
         6'd11: w = 17'd7620;
         6'd12: w = 17'd6100;
         6'd13: w = 17'd4904;
         6'd14: w = 17'd3906;
         6'd15: w = 17'd3121;
         6'd16: w = 17'd2501;
         6'd17: w = 17'd1991;
         6'd18: w = 17'd1586;
         6'd19: w = 17'd1277;
         6'd20: w = 17'd1024;
         6'd21: w = 17'd820;
         6'd22: w = 17'd655;
         6'd23: w = 17'd526;
         6'd24: w = 17'd423;
         6'd25: w = 17'd335;
         6'd26: w = 17'd272;
         6'd27: w = 17'd215;
         6'd28: w = 17'd172;
         6'd29: w = 17'd137;
         6'd30: w = 17'd110;
         6'd31: w = 17'd87;
         6'd32: w = 17'd70;
         6'd33: w = 17'd56;
         6'd34: w = 17'd45;
         6'd35: w = 17'd36;
         6'd36: w = 17'd29;
         6'd37: w = 17'd23;
         6'd38: w = 17'd18;
         default: w = 17'd15;
      endcase
      return w;
   endfunction

   // Wake credit, 1024000 divided by the weight of a nice level.
   function automatic logic [WEIGHT_W-1:0] credit_of(input logic [NICE_W-1:0] nice);
      logic [WEIGHT_W-1:0] c;
      case (nice)
         6'd0:  c = 17'd11;
         6'd1:  c = 17'd14;
         6'd2:  c = 17'd18;
         6'd3:  c = 17'd22;
         6'd4:  c = 17'd28;
         6'd5:  c = 17'd35;
         6'd6:  c = 17'd44;
         6'd7:  c = 17'd54;
         6'd8:  c = 17'd68;
         6'd9:  c = 17'd85;
         6'd10: c = 17'd107;
         6'd11: c = 17'd134;
         6'd12: c = 17'd167;
         6'd13: c = 17'd208;
         6'd14: c = 17'd262;
         6'd15: c = 17'd328;
         6'd16: c = 17'd409;
         6'd17: c = 17'd514;
         6'd18: c = 17'd645;
         6'd19: c = 17'd801;
         6'd20: c = 17'd1000;
         6'd21: c = 17'd1248;
         6'd22: c = 17'd1563;
         6'd23: c = 17'd1946;
         6'd24: c = 17'd2420;
         6'd25: c = 17'd3056;
         6'd26: c = 17'd3764;
         6'd27: c = 17'd4762;
         6'd28: c = 17'd5953;
         6'd29: c = 17'd7474;
         6'd30: c = 17'd9309;
         6'd31: c = 17'd11770;
         6'd32: c = 17'd14628;
         6'd33: c = 17'd18285;
         6'd34: c = 17'd22755;
         6'd35: c = 17'd28444;
         6'd36: c = 17'd35310;
         6'd37: c = 17'd44521;
         6'd38: c = 17'd56888;
         default: c = 17'd68266;
      endcase
      return c;
   endfunction

endpackage

### src/fair_share_task_picker_core.sv
// Top level of the fair-share task picker: sequencer, scan datapath and result register.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   operation, slot, parent_slot, channel,
//                                              nice_value, charge_amount
//   rsp_      out        rsp_valid/rsp_stall   status, chosen_slot, timeslice,
//                                              nice_level, virtual_runtime
//   csr_      in         csr_write             csr_index, csr_wdata
//
// One transaction at a time; req_stall is high from acceptance until the result is taken.
// Pick: a scan of the table, a multiply state, a divider start state, then a wait on
// the 33 quotient steps of the serial divider.
// Wake: two scans of the table. Other operations: a single execute state.
// The single read port of the slot table sets the scan length.
// Reset clears the slot states; there is no clearing pass.
module fair_share_task_picker_core import fstp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int VRUNTIME_BITS = VRUNTIME_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_operation,
   input  logic [5:0]          req_slot,
   input  logic [5:0]          req_parent_slot,
   input  logic [CHAN_W-1:0]   req_channel,
   input  logic [NICE_W-1:0]   req_nice_value,
   input  logic [31:0]         req_charge_amount,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [5:0]          rsp_chosen_slot,
   output logic [BUDGET_W-1:0] rsp_timeslice,
   output logic [NICE_W-1:0]   rsp_nice_level,
   output logic [RSP_VR_W-1:0] rsp_virtual_runtime,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [BUDGET_W-1:0] csr_wdata
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int VRB = VRUNTIME_BITS;
   localparam int TOT_W = WEIGHT_W + $clog2(SLOTS) + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_WAKE,
      ST_MULT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [BUDGET_W-1:0] budget_ff;
   logic [NICE_W-1:0]   def_nice_ff;

   // Latched request.
   logic [3:0]        op_ff;
   logic [5:0]        slot_ff;
   logic [5:0]        par_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [NICE_W-1:0] nv_ff;
   logic [31:0]       amt_ff;

   // Scan state.
   logic [CNT_W-1:0]  cnt_ff;
   logic              dv_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              found_ff;
   logic [SLOT_W-1:0] best_ff;
   logic [VRB-1:0]    best_vr_ff;
   logic [NICE_W-1:0] best_nice_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [PROD_W-1:0] prod_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [5:0]          rsp_slot_ff;
   logic [BUDGET_W-1:0] rsp_ts_ff;
   logic [NICE_W-1:0]   rsp_nice_ff;
   logic [RSP_VR_W-1:0] rsp_vr_ff;

   // Slot table ports.
   logic [SLOT_W-1:0] rd_addr;
   logic [1:0]        rd_status;
   logic [NICE_W-1:0] rd_nice;
   logic [VRB-1:0]    rd_vr;
   logic [CHAN_W-1:0] rd_chan;
   slot_we_type       we;
   logic [SLOT_W-1:0] wr_addr;
   logic [1:0]        wr_status;
   logic [NICE_W-1:0] wr_nice;
   logic [VRB-1:0]    wr_vr;
   logic [CHAN_W-1:0] wr_chan;

   // Divider ports.
   logic              div_start;
   logic              div_busy;
   logic [PROD_W-1:0] div_quo;

   // Per-operation results of the execute cycle.
   logic [1:0]        ex_status;
   logic              ex_zero;
   logic [NICE_W-1:0] ex_nice;
   logic [VRB-1:0]    ex_vr;

   logic              req_accept;
   logic              slot_ok;
   logic              par_ok;
   logic [VRB:0]      charge_sum;
   logic [VRB-1:0]    wake_credit;
   logic              better;

   assign req_accept = req_valid && !req_stall;
   assign slot_ok    = 32'(slot_ff) < SLOTS;
   assign par_ok     = 32'(par_ff) < SLOTS;
   assign charge_sum = {1'b0, rd_vr} + (VRB + 1)'(amt_ff);
   assign wake_credit = VRB'(credit_of(rd_nice));
   assign better     = !found_ff || (rd_vr < best_vr_ff);

   fstp_slot_store #(
      .SLOTS(SLOTS),
      .VRUNTIME_BITS(VRUNTIME_BITS)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .rd_addr(rd_addr),
      .rd_status(rd_status),
      .rd_nice(rd_nice),
      .rd_vr(rd_vr),
      .rd_chan(rd_chan),
      .we(we),
      .wr_addr(wr_addr),
      .wr_status(wr_status),
      .wr_nice(wr_nice),
      .wr_vr(wr_vr),
      .wr_chan(wr_chan)
   );

   fstp_divider #(
      .N(PROD_W),
      .D(TOT_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(prod_ff),
      .divisor(total_ff),
      .busy(div_busy),
      .quotient(div_quo)
   );

   // Read address: the addressed slot (the parent slot for a fork) on acceptance, the scan counter while scanning.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         if (op_type'(req_operation) == OP_FORK) begin
            rd_addr = SLOT_W'(req_parent_slot);
         end else begin
            rd_addr = SLOT_W'(req_slot);
         end
      end else begin
         rd_addr = cnt_ff[SLOT_W-1:0];
      end
   end

   // Table writes and execute-cycle results.
   always_comb begin
      we        = '0;
      wr_addr   = SLOT_W'(slot_ff);
      wr_status = SLOT_RUNNABLE;
      wr_nice   = rd_nice;
      wr_vr     = rd_vr;
      wr_chan   = chan_ff;
      ex_status = RES_OK;
      ex_zero   = 1'b0;
      ex_nice   = rd_nice;
      ex_vr     = rd_vr;
      div_start = (state_ff == ST_DIV_START);
      case (state_ff)
         ST_EXEC: begin
            case (op_ff)
               OP_CREATE: begin
                  if (!slot_ok) begin
                     ex_status = RES_UNUSED;
                     ex_zero   = 1'b1;
                  end else begin
                     we.status = 1'b1;
                     we.nice   = 1'b1;
                     we.vr     = 1'b1;
                     wr_nice   = (def_nice_ff > NICE_W'(NICE_MAX)) ? NICE_W'(NICE_MAX)
                                                                     : def_nice_ff;
                     wr_vr     = '0;
                     ex_nice   = wr_nice;
                     ex_vr     = '0;
                  end
               end
               OP_FORK: begin
                  if (!slot_ok || !par_ok || rd_status == SLOT_UNUSED) begin
                     ex_status = RES_UNUSED;
                     ex_zero   = 1'b1;
                  end else begin
                     we.status = 1'b1;
                     we.nice   = 1'b1;
                     we.vr     = 1'b1;
                  end
               end
               OP_SLEEP, OP_YIELD, OP_SETNICE, OP_GETNICE, OP_CHARGE, OP_REMOVE: begin
                  if (!slot_ok || rd_status == SLOT_UNUSED) begin
                     ex_status = RES_UNUSED;
                     ex_zero   = 1'b1;
                  end else begin
                     case (op_ff)
                        OP_SLEEP: begin
                           we.status = 1'b1;
                           we.chan   = 1'b1;
                           wr_status = SLOT_SLEEPING;
                        end
                        OP_YIELD: begin
                           we.status = 1'b1;
                        end
                        OP_SETNICE: begin
                           if (nv_ff > NICE_W'(NICE_MAX)) begin
                              ex_status = RES_BAD_NICE;
                           end else begin
                              we.nice = 1'b1;
                              wr_nice = nv_ff;
                              ex_nice = nv_ff;
                           end
                        end
                        OP_CHARGE: begin
                           we.vr = 1'b1;
                           wr_vr = charge_sum[VRB] ? '1 : charge_sum[VRB-1:0];
                           ex_vr = wr_vr;
                        end
                        OP_REMOVE: begin
                           we.status = 1'b1;
                           wr_status = SLOT_UNUSED;
                           ex_zero   = 1'b1;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               default: begin
                  ex_zero = 1'b1;
               end
            endcase
         end
         ST_WAKE: begin
            wr_addr = idx_ff;
            if (dv_ff && rd_status == SLOT_SLEEPING && rd_chan == chan_ff) begin
               we.status = 1'b1;
               we.vr     = 1'b1;
               wr_vr     = (found_ff && best_vr_ff > wake_credit) ? best_vr_ff - wake_credit
                                                                  : '0;
            end
         end
         ST_MULT: begin
            we.status = 1'b1;
            wr_addr   = best_ff;
            wr_status = SLOT_RUNNING;
         end
         default: begin
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff   <= BUDGET_RESET;
         def_nice_ff <= DEF_NICE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            2'(CSR_SLICE_BUDGET): budget_ff   <= csr_wdata;
            2'(CSR_DEFAULT_NICE): def_nice_ff <= csr_wdata[NICE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer with scan registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  op_ff    <= req_operation;
                  slot_ff  <= req_slot;
                  par_ff   <= req_parent_slot;
                  chan_ff  <= req_channel;
                  nv_ff    <= req_nice_value;
                  amt_ff   <= req_charge_amount;
                  cnt_ff   <= '0;
                  dv_ff    <= 1'b0;
                  found_ff <= 1'b0;
                  total_ff <= '0;
                  if (op_type'(req_operation) == OP_PICK ||
                      op_type'(req_operation) == OP_WAKE) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_EXEC;
                  end
               end
            end
            ST_EXEC: begin
               rsp_status_ff <= ex_status;
               rsp_slot_ff   <= (op_ff > OP_REMOVE) ? 6'd0 : slot_ff;
               rsp_ts_ff     <= '0;
               rsp_nice_ff   <= ex_zero ? '0 : ex_nice;
               rsp_vr_ff     <= ex_zero ? '0 : RSP_VR_W'(ex_vr);
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_RESP;
            end
            ST_SCAN: begin
               // Issue the next read and fold in the data of the previous one.
               if (32'(cnt_ff) < SLOTS) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  idx_ff <= cnt_ff[SLOT_W-1:0];
                  dv_ff  <= 1'b1;
               end else begin
                  dv_ff <= 1'b0;
               end
               if (dv_ff && rd_status == SLOT_RUNNABLE) begin
                  total_ff <= total_ff + TOT_W'(weight_of(rd_nice));
                  if (better) begin
                     found_ff     <= 1'b1;
                     best_ff      <= idx_ff;
                     best_vr_ff   <= rd_vr;
                     best_nice_ff <= rd_nice;
                  end
               end
               if (32'(cnt_ff) == SLOTS && !dv_ff) begin
                  if (op_ff == OP_WAKE) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_WAKE;
                  end else if (!found_ff) begin
                     rsp_status_ff <= RES_NONE;
                     rsp_slot_ff   <= '0;
                     rsp_ts_ff     <= '0;
                     rsp_nice_ff   <= '0;
                     rsp_vr_ff     <= '0;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= ST_RESP;
                  end else begin
                     state_ff <= ST_MULT;
                  end
               end
            end
            ST_WAKE: begin
               if (32'(cnt_ff) < SLOTS) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  idx_ff <= cnt_ff[SLOT_W-1:0];
                  dv_ff  <= 1'b1;
               end else begin
                  dv_ff <= 1'b0;
               end
               if (32'(cnt_ff) == SLOTS && !dv_ff) begin
                  rsp_status_ff <= RES_OK;
                  rsp_slot_ff   <= '0;
                  rsp_ts_ff     <= '0;
                  rsp_nice_ff   <= '0;
                  rsp_vr_ff     <= '0;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_RESP;
               end
            end
            ST_MULT: begin
               prod_ff  <= PROD_W'(budget_ff) * PROD_W'(weight_of(best_nice_ff));
               state_ff <= ST_DIV_START;
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (!div_busy) begin
                  rsp_status_ff <= RES_OK;
                  rsp_slot_ff   <= 6'(best_ff);
                  rsp_ts_ff     <= div_quo[BUDGET_W-1:0];
                  rsp_nice_ff   <= best_nice_ff;
                  rsp_vr_ff     <= RSP_VR_W'(best_vr_ff);
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chosen_slot     = rsp_slot_ff;
   assign rsp_timeslice       = rsp_ts_ff;
   assign rsp_nice_level      = rsp_nice_ff;
   assign rsp_virtual_runtime = rsp_vr_ff;

endmodule

### src/fstp_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module fstp_divider #(
   parameter int N = 33,
   parameter int D = 27
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         busy,
   output logic [N-1:0] quotient
);

   localparam int CNT_W = $clog2(N + 1);

   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic [D:0]       rem_ff;
   logic [N-1:0]     quo_ff;
   logic [D-1:0]     dsr_ff;

   logic [D:0] shifted;
   logic [D:0] diff;
   logic       take;

   // One restoring step.
   always_comb begin
      shifted = {rem_ff[D-1:0], quo_ff[N-1]};
      take    = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_W'(N);
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath of the iteration.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? diff : shifted;
         quo_ff <= {quo_ff[N-2:0], take};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### src/fstp_slot_store.sv
// Slot table: state flops with reset plus nice, vruntime and channel memories.
module fstp_slot_store import fstp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int VRUNTIME_BITS = VRUNTIME_BITS_DEFAULT,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [SLOT_W-1:0]        rd_addr,
   output logic [1:0]               rd_status,
   output logic [NICE_W-1:0]        rd_nice,
   output logic [VRUNTIME_BITS-1:0] rd_vr,
   output logic [CHAN_W-1:0]        rd_chan,
   input  slot_we_type              we,
   input  logic [SLOT_W-1:0]        wr_addr,
   input  logic [1:0]               wr_status,
   input  logic [NICE_W-1:0]        wr_nice,
   input  logic [VRUNTIME_BITS-1:0] wr_vr,
   input  logic [CHAN_W-1:0]        wr_chan
);

   logic [1:0]               status_ff [SLOTS];
   logic [NICE_W-1:0]        nice_mem  [SLOTS];
   logic [VRUNTIME_BITS-1:0] vr_mem    [SLOTS];
   logic [CHAN_W-1:0]        chan_mem  [SLOTS];

   logic [1:0]               rd_status_ff;
   logic [NICE_W-1:0]        rd_nice_ff;
   logic [VRUNTIME_BITS-1:0] rd_vr_ff;
   logic [CHAN_W-1:0]        rd_chan_ff;

   // Slot states are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            status_ff[i] <= SLOT_UNUSED;
         end
      end else if (we.status) begin
         status_ff[wr_addr] <= wr_status;
      end
   end

   // Memories have no reset; every used slot is written before it is read.
   always_ff @(posedge clock) begin
      if (we.nice) begin
         nice_mem[wr_addr] <= wr_nice;
      end
      if (we.vr) begin
         vr_mem[wr_addr] <= wr_vr;
      end
      if (we.chan) begin
         chan_mem[wr_addr] <= wr_chan;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_status_ff <= status_ff[rd_addr];
      rd_nice_ff   <= nice_mem[rd_addr];
      rd_vr_ff     <= vr_mem[rd_addr];
      rd_chan_ff   <= chan_mem[rd_addr];
   end

   assign rd_status = rd_status_ff;
   assign rd_nice   = rd_nice_ff;
   assign rd_vr     = rd_vr_ff;
   assign rd_chan   = rd_chan_ff;

endmodule

### tb/fair_share_task_picker_core_test.sv
// Self-checking testbench for the fair-share task picker core.
`timescale 1ns / 1ps

module fair_share_task_picker_core_test;
   import fstp_pkg::*;

   localparam int NUM_SLOTS = 64;
   localparam logic [47:0] VR_LIMIT = 48'hFFFF_FFFF_FFFF;
   localparam int RANDOM_ITEMS = 1300;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [3:0]  op;
      logic [5:0]  slot;
      logic [5:0]  parent;
      logic [31:0] chan;
      logic [5:0]  nice;
      logic [31:0] amount;
   } task_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [15:0] slice;
      logic [5:0]  nice;
      logic [47:0] vr;
   } task_rsp_type;

   // Scoreboard: shadow slot table plus the queue of predicted responses.
   class sched_scoreboard;
      logic [1:0]  slot_st[NUM_SLOTS];
      logic [5:0]  slot_nice[NUM_SLOTS];
      logic [47:0] slot_vr[NUM_SLOTS];
      logic [31:0] slot_chan[NUM_SLOTS];
      logic [15:0] budget;
      logic [5:0]  def_nice;
      task_rsp_type pending[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned weights[40] = '{
         88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705, 14949, 11916,
         9548, 7620, 6100, 4904, 3906, 3121, 2501, 1991, 1586, 1277,
         1024, 820, 655, 526, 423, 335, 272, 215, 172, 137,
         110, 87, 70, 56, 45, 36, 29, 23, 18, 15};

      function new();
         budget = BUDGET_RESET;
         def_nice = DEF_NICE_RESET;
         mismatches = 0;
         checked = 0;
         foreach (slot_st[i]) begin
            slot_st[i] = SLOT_UNUSED;
            slot_nice[i] = '0;
            slot_vr[i] = '0;
            slot_chan[i] = '0;
         end
      endfunction

      function int unsigned weight(logic [5:0] n);
         return weights[(n > NICE_MAX) ? NICE_MAX : n];
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         if (idx == CSR_SLICE_BUDGET) budget = data;
         else if (idx == CSR_DEFAULT_NICE) def_nice = data[5:0];
      endfunction

      // Predicts the response of one accepted transaction and updates the table.
      function void note_request(task_req_type r);
         task_rsp_type e;
         longint unsigned total, credit;
         logic [47:0] minvr;
         int best;
         bit found;
         e = '{RES_OK, 6'd0, 16'd0, 6'd0, 48'd0};
         case (r.op)
            OP_PICK: begin
               total = 0;
               best = 0;
               found = 0;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_st[i] != SLOT_RUNNABLE) continue;
                  total += weight(slot_nice[i]);
                  if (!found || slot_vr[i] < slot_vr[best]) begin
                     best = i;
                     found = 1;
                  end
               end
               if (!found) begin
                  e.status = RES_NONE;
               end else begin
                  slot_st[best] = SLOT_RUNNING;
                  e.slot = 6'(best);
                  e.slice = 16'((longint'(budget) * weight(slot_nice[best])) / total);
                  e.nice = slot_nice[best];
                  e.vr = slot_vr[best];
               end
            end
            OP_WAKE: begin
               found = 0;
               minvr = '0;
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (slot_st[i] == SLOT_RUNNABLE && (!found || slot_vr[i] < minvr)) begin
                     minvr = slot_vr[i];
                     found = 1;
                  end
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (slot_st[i] == SLOT_SLEEPING && slot_chan[i] == r.chan) begin
                     credit = 1024000 / weight(slot_nice[i]);
                     slot_st[i] = SLOT_RUNNABLE;
                     slot_vr[i] = (found && minvr > credit) ? 48'(minvr - credit) : 48'd0;
                  end
            end
            OP_CREATE, OP_FORK: begin
               e.slot = r.slot;
               if (r.op == OP_FORK && slot_st[r.parent] == SLOT_UNUSED) begin
                  e.status = RES_UNUSED;
               end else begin
                  if (r.op == OP_CREATE) begin
                     slot_nice[r.slot] = (def_nice > NICE_MAX) ? 6'(NICE_MAX) : def_nice;
                     slot_vr[r.slot] = '0;
                  end else begin
                     slot_nice[r.slot] = slot_nice[r.parent];
                     slot_vr[r.slot] = slot_vr[r.parent];
                  end
                  slot_st[r.slot] = SLOT_RUNNABLE;
                  e.nice = slot_nice[r.slot];
                  e.vr = slot_vr[r.slot];
               end
            end
            OP_SLEEP, OP_YIELD, OP_SETNICE, OP_GETNICE, OP_CHARGE, OP_REMOVE: begin
               e.slot = r.slot;
               if (slot_st[r.slot] == SLOT_UNUSED) begin
                  e.status = RES_UNUSED;
               end else if (r.op == OP_REMOVE) begin
                  slot_st[r.slot] = SLOT_UNUSED;
               end else begin
                  case (r.op)
                     OP_SLEEP: begin
                        slot_st[r.slot] = SLOT_SLEEPING;
                        slot_chan[r.slot] = r.chan;
                     end
                     OP_YIELD: slot_st[r.slot] = SLOT_RUNNABLE;
                     OP_SETNICE:
                        if (r.nice > NICE_MAX) e.status = RES_BAD_NICE;
                        else slot_nice[r.slot] = r.nice;
                     OP_CHARGE:
                        if (VR_LIMIT - slot_vr[r.slot] < 48'(r.amount))
                           slot_vr[r.slot] = VR_LIMIT;
                        else
                           slot_vr[r.slot] = slot_vr[r.slot] + 48'(r.amount);
                     default: ;
                  endcase
                  e.nice = slot_nice[r.slot];
                  e.vr = slot_vr[r.slot];
               end
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      // Compares one accepted response with the oldest prediction.
      function void check_response(task_rsp_type a);
         task_rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with nothing pending at %0t", $realtime);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.status !== e.status || a.slot !== e.slot || a.slice !== e.slice ||
             a.nice !== e.nice || a.vr !== e.vr) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response %0d expected st=%0d slot=%0d ts=%0d nice=%0d ",
                         "vr=%0d, got st=%0d slot=%0d ts=%0d nice=%0d vr=%0d"},
                        checked, e.status, e.slot, e.slice, e.nice, e.vr,
                        a.status, a.slot, a.slice, a.nice, a.vr);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_operation = '0;
   logic [5:0]  req_slot = '0;
   logic [5:0]  req_parent_slot = '0;
   logic [31:0] req_channel = '0;
   logic [5:0]  req_nice_value = '0;
   logic [31:0] req_charge_amount = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_chosen_slot;
   logic [15:0] rsp_timeslice;
   logic [5:0]  rsp_nice_level;
   logic [47:0] rsp_virtual_runtime;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sched_scoreboard sb = new();
   bit          quiet = 0;
   int          hold_count = 0;
   int unsigned op_counts[16];
   int unsigned sent = 0;

   fair_share_task_picker_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_count > 0) begin
            rsp_stall = 1'b1;
            hold_count--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 17);
            rsp_stall = 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Every accepted response transaction is checked.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_status, rsp_chosen_slot, rsp_timeslice,
                             rsp_nice_level, rsp_virtual_runtime});

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Offers one request, with an optional idle burst first, until it is accepted.
   task automatic send_request(task_req_type r);
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 17);
         repeat (n) @(negedge clock);
      end
      req_operation = r.op;
      req_slot = r.slot;
      req_parent_slot = r.parent;
      req_channel = r.chan;
      req_nice_value = r.nice;
      req_charge_amount = r.amount;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      op_counts[r.op]++;
      sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   // Register writes happen only with nothing in flight.
   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      drain();
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_write = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic send_op(logic [3:0] op, logic [5:0] s, logic [5:0] p,
                          logic [31:0] ch, logic [5:0] nv, logic [31:0] amt);
      send_request('{op, s, p, ch, nv, amt});
   endtask

   // Random request biased toward a few slots and channels so that state builds up.
   function automatic task_req_type random_request();
      task_req_type r;
      int k;
      k = $urandom_range(0, 99);
      if (k < 20) r.op = OP_PICK;
      else if (k < 30) r.op = OP_WAKE;
      else if (k < 40) r.op = OP_SLEEP;
      else if (k < 50) r.op = OP_YIELD;
      else if (k < 62) r.op = OP_CREATE;
      else if (k < 70) r.op = OP_FORK;
      else if (k < 78) r.op = OP_SETNICE;
      else if (k < 84) r.op = OP_GETNICE;
      else if (k < 94) r.op = OP_CHARGE;
      else if (k < 98) r.op = OP_REMOVE;
      else r.op = 4'($urandom_range(10, 15));
      r.slot = 6'(($urandom_range(0, 6) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 63));
      r.parent = 6'(($urandom_range(0, 6) != 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 63));
      r.chan = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 3) : $urandom;
      r.nice = 6'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 39)
                                               : $urandom_range(0, 63));
      r.amount = $urandom_range(0, 1) ? $urandom_range(0, 100000) : $urandom;
      return r;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of the fields and each corner of the operations.
      send_op(OP_PICK, 0, 0, 0, 0, 0);
      send_op(OP_CREATE, 0, 0, 0, 0, 0);
      send_op(OP_CREATE, 63, 63, 0, 0, 0);
      send_op(OP_PICK, 0, 0, 0, 0, 0);
      send_op(OP_PICK, 0, 0, 0, 0, 0);
      send_op(OP_PICK, 0, 0, 0, 0, 0);
      send_op(OP_SLEEP, 0, 0, 32'hFFFF_FFFF, 0, 0);
      send_op(OP_WAKE, 0, 0, 32'hFFFF_FFFF, 0, 0);
      send_op(OP_SLEEP, 63, 0, 5, 0, 0);
      send_op(OP_CHARGE, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_op(OP_WAKE, 0, 0, 5, 0, 0);
      send_op(OP_SETNICE, 63, 0, 0, 63, 0);
      send_op(OP_SETNICE, 63, 0, 0, 0, 0);
      send_op(OP_GETNICE, 63, 0, 0, 0, 0);
      send_op(OP_FORK, 2, 63, 0, 0, 0);
      send_op(OP_FORK, 3, 40, 0, 0, 0);
      send_op(OP_YIELD, 0, 0, 0, 0, 0);
      send_op(OP_CHARGE, 50, 0, 0, 0, 1);
      send_op(OP_REMOVE, 2, 0, 0, 0, 0);
      send_op(OP_GETNICE, 2, 0, 0, 0, 0);
      send_op(4'd10, 0, 0, 0, 0, 0);
      send_op(4'd15, 63, 63, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF);
      send_op(OP_PICK, 0, 0, 0, 0, 0);

      // Back-to-back charges of the largest amount on one slot.
      quiet = 1;
      repeat (40) send_op(OP_CHARGE, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_op(OP_WAKE, 0, 0, 0, 0, 0);
      send_op(OP_PICK, 0, 0, 0, 0, 0);
      quiet = 0;

      // Random phases under several register settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin write_reg(CSR_SLICE_BUDGET, 16'd1); write_reg(CSR_DEFAULT_NICE, 16'd0); end
            2: begin
               write_reg(CSR_SLICE_BUDGET, 16'hFFFF);
               write_reg(CSR_DEFAULT_NICE, 16'd39);
            end
            3: begin
               write_reg(CSR_SLICE_BUDGET, 16'($urandom_range(1, 65535)));
               write_reg(CSR_DEFAULT_NICE, 16'hFFFF);
            end
            4: begin
               write_reg(2'd3, 16'hFFFF);
               write_reg(CSR_DEFAULT_NICE, 16'($urandom_range(0, 39)));
            end
            5: begin
               write_reg(CSR_SLICE_BUDGET, 16'd10000);
               write_reg(CSR_DEFAULT_NICE, 16'd20);
            end
            default: ;
         endcase
         if (phase == 2) hold_count = LONG_HOLD;
         if (phase == 5) quiet = 1;
         for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
            if (i == 100 && phase == 3) drain();
            send_request(random_request());
         end
      end

      drain();
      repeat (300) @(posedge clock);
      $display("Sent %0d requests: %0d picks, %0d wakes, %0d creates, %0d forks, %0d charges.",
               sent, op_counts[OP_PICK], op_counts[OP_WAKE], op_counts[OP_CREATE],
               op_counts[OP_FORK], op_counts[OP_CHARGE]);
      $display("Checked %0d responses across six register settings, %0d mismatches.",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
